// File: rtl/nps_pkg.sv
package nps_pkg;

  // transaction kinds on the request channel
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // width of the reported target index
  localparam int unsigned OUT_IDX_BITS = 10;

  typedef logic [OUT_IDX_BITS-1:0] nps_idx_t;

  // control that travels with each target through the distance pipeline
  typedef struct packed {
    logic vld;
    logic last;
  } nps_tag_t;

endpackage

// File: rtl/nps_in_if.sv
interface nps_in_if #(
  parameter int unsigned COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   kind;
  logic signed [COORD_BITS-1:0] px;
  logic signed [COORD_BITS-1:0] py;
  logic signed [COORD_BITS-1:0] pz;

  modport source (output valid, kind, px, py, pz, input ready);
  modport sink   (input valid, kind, px, py, pz, output ready);
endinterface

// File: rtl/nps_out_if.sv
interface nps_out_if;
  logic              valid;
  logic              ready;
  logic              found;
  nps_pkg::nps_idx_t nearest_index;

  modport source (output valid, found, nearest_index, input ready);
  modport sink   (input valid, found, nearest_index, output ready);
endinterface

// File: rtl/nps_ram.sv
module nps_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/nps_dist.sv
module nps_dist #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned IDX_BITS   = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [3*COORD_BITS-1:0]    qpt_i,
  input  logic [3*COORD_BITS-1:0]    tpt_i,
  input  nps_pkg::nps_tag_t          tag_i,
  input  logic [IDX_BITS-1:0]        idx_i,
  output nps_pkg::nps_tag_t          tag_o,
  output logic [IDX_BITS-1:0]        idx_o,
  output logic [2*COORD_BITS+1:0]    dist_o
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned DW = 2 * COORD_BITS + 2;

  nps_pkg::nps_tag_t   tag0_q, tag1_q, tag2_q, tag3_q;
  logic [IDX_BITS-1:0] idx0_q, idx1_q, idx2_q, idx3_q;
  logic [CB-1:0]       abs_d [3];
  logic [CB-1:0]       abs_q [3];
  logic [2*CB-1:0]     sq_q  [3];
  logic [DW-1:0]       sum_q;

  // per-axis absolute difference, aligned with the registered ram read
  for (genvar k = 0; k < 3; k++) begin : g_axis
    logic [CB:0] diff;
    logic [CB:0] ndiff;
    assign diff  = {qpt_i[k*CB+CB-1], qpt_i[k*CB +: CB]}
                 - {tpt_i[k*CB+CB-1], tpt_i[k*CB +: CB]};
    assign ndiff = -diff;
    assign abs_d[k] = diff[CB] ? ndiff[CB-1:0] : diff[CB-1:0];

    always_ff @(posedge clk_i) begin
      abs_q[k] <= abs_d[k];
      sq_q[k]  <= (2*CB)'(abs_q[k]) * (2*CB)'(abs_q[k]);
    end
  end

  // sum of the three squares
  always_ff @(posedge clk_i) begin
    sum_q <= DW'(sq_q[0]) + DW'(sq_q[1]) + DW'(sq_q[2]);
  end

  // tag and index pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag0_q <= '0;
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else begin
      tag0_q <= tag_i;
      tag1_q <= tag0_q;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx0_q <= idx_i;
    idx1_q <= idx0_q;
    idx2_q <= idx1_q;
    idx3_q <= idx2_q;
  end

  assign tag_o  = tag3_q;
  assign idx_o  = idx3_q;
  assign dist_o = sum_q;

endmodule

// File: rtl/nearest_point_search.sv
// Brute-force nearest neighbor search over a store of up to MAX_TARGETS 3D
// points with signed COORD_BITS coordinates. A load transaction appends one
// target (dropped when the store is full), a clear transaction empties the
// store, both with no response. A query transaction walks every stored
// target through one distance pipeline fed by the single read port of the
// target ram, one target per cycle, and returns the index of the target
// with the smallest exact squared distance, lowest index on ties, with
// found low when the store is empty. A query holds the request channel
// (ready low) until its response is loaded, which waits for any previous
// response to be taken. The target ram is not cleared; only entries loaded
// since the last clear are ever read.
module nearest_point_search #(
  parameter int unsigned MAX_TARGETS = 1024,
  parameter int unsigned COORD_BITS  = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  nps_in_if.sink        req_i,
  nps_out_if.source     rsp_o
);

  localparam int unsigned IW = $clog2(MAX_TARGETS);
  localparam int unsigned CW = $clog2(MAX_TARGETS + 1);
  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned DW = 2 * COORD_BITS + 2;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StScan  = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;
  localparam logic [1:0] StResp  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [CW-1:0]     cnt_q;
  logic [IW-1:0]     scan_q;
  logic [3*CB-1:0]   qpt_q;
  logic              have_q;
  logic [DW-1:0]     best_dist_q;
  logic [IW-1:0]     best_idx_q;
  logic              rsp_valid_q;
  logic              found_q;
  nps_pkg::nps_idx_t index_q;

  logic              accept;
  logic              full;
  logic              load_we;
  logic              scan_last;
  logic              rsp_load;
  logic              better;
  nps_pkg::nps_tag_t issue_tag;
  nps_pkg::nps_tag_t pipe_tag;
  logic [IW-1:0]     pipe_idx;
  logic [DW-1:0]     pipe_dist;
  logic [3*CB-1:0]   tpt;

  assign req_i.ready = (state_q == StIdle);
  assign accept      = req_i.valid && req_i.ready;
  assign full        = (cnt_q >= CW'(MAX_TARGETS));
  assign load_we     = accept && (req_i.kind == nps_pkg::KIND_LOAD) && !full;
  assign scan_last   = (CW'(scan_q) == cnt_q - CW'(1));
  assign rsp_load    = (state_q == StResp) && (!rsp_valid_q || rsp_o.ready);

  assign issue_tag.vld  = (state_q == StScan);
  assign issue_tag.last = scan_last;

  // target store
  nps_ram #(
    .WIDTH (3 * CB),
    .DEPTH (MAX_TARGETS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (cnt_q[IW-1:0]),
    .wdata_i ({req_i.pz, req_i.py, req_i.px}),
    .raddr_i (scan_q),
    .rdata_o (tpt)
  );

  // shared squared distance pipeline
  nps_dist #(
    .COORD_BITS (CB),
    .IDX_BITS   (IW)
  ) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .qpt_i  (qpt_q),
    .tpt_i  (tpt),
    .tag_i  (issue_tag),
    .idx_i  (scan_q),
    .tag_o  (pipe_tag),
    .idx_o  (pipe_idx),
    .dist_o (pipe_dist)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept && (req_i.kind == nps_pkg::KIND_QUERY)) begin
          state_d = (cnt_q == '0) ? StResp : StScan;
        end
      end
      StScan: begin
        if (scan_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (pipe_tag.vld && pipe_tag.last) begin
          state_d = StResp;
        end
      end
      StResp: begin
        if (rsp_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control registers: state, count, scan index, best valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      scan_q  <= '0;
      have_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        unique case (req_i.kind)
          nps_pkg::KIND_LOAD: begin
            if (!full) begin
              cnt_q <= cnt_q + CW'(1);
            end
          end
          nps_pkg::KIND_CLEAR: begin
            cnt_q <= '0;
          end
          nps_pkg::KIND_QUERY: begin
            scan_q <= '0;
            have_q <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (state_q == StScan) begin
        scan_q <= scan_q + IW'(1);
      end
      if (better) begin
        have_q <= 1'b1;
      end
    end
  end

  // strict compare keeps the lowest index on ties
  assign better = pipe_tag.vld && (!have_q || (pipe_dist < best_dist_q));

  always_ff @(posedge clk_i) begin
    if (accept && (req_i.kind == nps_pkg::KIND_QUERY)) begin
      qpt_q <= {req_i.pz, req_i.py, req_i.px};
    end
    if (better) begin
      best_dist_q <= pipe_dist;
      best_idx_q  <= pipe_idx;
    end
  end

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      found_q <= have_q;
      index_q <= have_q ? nps_pkg::nps_idx_t'(best_idx_q) : '0;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.found         = found_q;
  assign rsp_o.nearest_index = index_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_TARGETS))
    else $error("target count above capacity");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (CW'(scan_q) < cnt_q))
    else $error("scan index beyond stored targets");

  a_pipe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pipe_tag.vld |-> ((state_q == StScan) || (state_q == StDrain)))
    else $error("distance result outside a query");

  a_drain_has_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDrain && state_d == StResp) |=> have_q)
    else $error("scan finished without a candidate");

  a_rsp_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q == StResp))
    else $error("response raised outside response state");
`endif

endmodule
